>>> rtl/core/ring_slot_pool_with_remove_unit_macros.svh
// Assertion macros shared by the RTL.
`ifndef RING_SLOT_POOL_WITH_REMOVE_UNIT_MACROS_SVH
`define RING_SLOT_POOL_WITH_REMOVE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define RSPR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`define RSPR_ASSERT_NORST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);
`else
`define RSPR_ASSERT(lbl, prop, msg)
`define RSPR_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

>>> rtl/core/rspr_pkg.sv
package rspr_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int HANDLE_W     = 32;
   localparam int COUNT_OUT_W  = 9;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_INVALID = 2'd3
   } rspr_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_REJECT    = 2'd2,
      ST_NOT_FOUND = 2'd3
   } rspr_status_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]    popped_handle;
      rspr_status_type        status;
      logic [COUNT_OUT_W-1:0] item_count;
   } rspr_result_type;

endpackage

>>> rtl/core/rspr_mem.sv
module rspr_mem #(
   parameter int CAPACITY = rspr_pkg::CAPACITY_DEF
) (
   input  logic                                     clock,
   input  logic                                     rd_en,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [rspr_pkg::HANDLE_W-1:0]            rd_data_ff,
   input  logic                                     wr_en,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   input  logic [rspr_pkg::HANDLE_W-1:0]            wr_data
);
   import rspr_pkg::*;

   localparam int RING = 1 << $clog2(CAPACITY);

   logic [HANDLE_W-1:0] slots [RING];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slots[rd_addr];
      end
   end

endmodule

>>> rtl/core/rspr_ctrl.sv
`include "ring_slot_pool_with_remove_unit_macros.svh"

module rspr_ctrl #(
   parameter int CAPACITY = rspr_pkg::CAPACITY_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_operation,
   input  logic [rspr_pkg::HANDLE_W-1:0]            req_handle,
   input  logic                                     out_free,
   output logic                                     fin,
   output rspr_pkg::rspr_result_type                result,
   output logic                                     mem_rd_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
   input  logic [rspr_pkg::HANDLE_W-1:0]            mem_rd_data,
   output logic                                     mem_wr_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
   output logic [rspr_pkg::HANDLE_W-1:0]            mem_wr_data
);
   import rspr_pkg::*;

   localparam int RING_LOG = $clog2(CAPACITY);
   localparam int RING     = 1 << RING_LOG;
   localparam int PTR_W    = (RING_LOG > 0) ? RING_LOG : 1;
   localparam int CNT_W    = RING_LOG + 1;
   localparam logic [PTR_W-1:0] PTR_MASK = PTR_W'(RING - 1);
   localparam logic [CNT_W-1:0] RING_CNT = CNT_W'(RING);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_TAKE,
      S_SEARCH,
      S_PLACE,
      S_DONE
   } state_type;

   state_type           state_ff,    state_in;
   logic [PTR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]    scan_left_ff, scan_left_in;
   logic                data_vld_ff, data_vld_in;
   logic [PTR_W-1:0]    data_idx_ff, data_idx_in;
   rspr_op_type         op_ff,       op_in;
   logic [HANDLE_W-1:0] key_ff,      key_in;
   logic [HANDLE_W-1:0] value_ff,    value_in;
   logic [PTR_W-1:0]    rp_ff,       rp_in;
   logic [PTR_W-1:0]    wp_ff,       wp_in;
   logic [CNT_W-1:0]    cnt_ff,      cnt_in;
   logic [HANDLE_W-1:0] popped_ff,   popped_in;
   rspr_status_type     status_ff,   status_in;

   logic                    match;
   logic                    hit;
   logic                    scanning;
   logic                    issue;
   logic [PTR_W-1:0]        idx_next;
   logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;
   rspr_op_type             req_op;

   assign req_op   = rspr_op_type'(req_operation);
   assign idx_next = PTR_W'(data_idx_ff + PTR_W'(1)) & PTR_MASK;
   assign cnt_wide = (CNT_W + COUNT_OUT_W)'(cnt_ff);

   always_comb begin
      unique case (state_ff)
         S_TAKE:   match = (mem_rd_data != '0);
         S_PLACE:  match = (mem_rd_data == '0);
         S_SEARCH: match = (mem_rd_data == key_ff);
         default:  match = 1'b0;
      endcase
   end

   assign scanning = (state_ff == S_TAKE) || (state_ff == S_SEARCH) || (state_ff == S_PLACE);
   assign hit      = scanning && data_vld_ff && match;
   assign issue    = scanning && !hit && (scan_left_ff != '0);

   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      scan_left_in = scan_left_ff;
      data_vld_in  = issue;
      data_idx_in  = scan_addr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;

      req_stall    = 1'b1;
      fin          = 1'b0;
      mem_rd_en    = issue;
      mem_rd_addr  = scan_addr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = data_idx_ff;
      mem_wr_data  = '0;

      result.popped_handle = popped_ff;
      result.status        = status_ff;
      result.item_count    = cnt_wide[COUNT_OUT_W-1:0];

      if (issue) begin
         scan_addr_in = PTR_W'(scan_addr_ff + PTR_W'(1)) & PTR_MASK;
         scan_left_in = scan_left_ff - CNT_W'(1);
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = scan_addr_ff;
            scan_addr_in = PTR_W'(scan_addr_ff + PTR_W'(1)) & PTR_MASK;
            scan_left_in = scan_left_ff - CNT_W'(1);
            if (scan_left_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in     = req_op;
               key_in    = req_handle;
               value_in  = req_handle;
               popped_in = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               scan_left_in = RING_CNT;
               unique case (req_op)
                  OP_PUSH: begin
                     if (req_handle == '0 || cnt_ff >= RING_CNT) begin
                        status_in = ST_REJECT;
                     end else begin
                        scan_addr_in = wp_ff;
                        state_in     = S_PLACE;
                     end
                  end
                  OP_POP, OP_REMOVE: begin
                     if (req_op == OP_REMOVE && req_handle == '0) begin
                        status_in = ST_REJECT;
                     end else if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        scan_addr_in = rp_ff;
                        state_in     = S_TAKE;
                     end
                  end
                  default: begin
                     status_in = ST_REJECT;
                  end
               endcase
            end
         end
         S_TAKE: begin
            if (hit) begin
               mem_wr_en = 1'b1;
               rp_in     = idx_next;
               cnt_in    = cnt_ff - CNT_W'(1);
               if (op_ff == OP_POP) begin
                  popped_in = mem_rd_data;
                  state_in  = S_DONE;
               end else if (mem_rd_data == key_ff) begin
                  state_in = S_DONE;
               end else begin
                  value_in     = mem_rd_data;
                  scan_addr_in = '0;
                  scan_left_in = RING_CNT;
                  state_in     = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = value_ff;
               state_in    = S_DONE;
            end else if (data_vld_ff && scan_left_ff == '0) begin
               status_in    = ST_NOT_FOUND;
               scan_addr_in = wp_ff;
               scan_left_in = RING_CNT;
               state_in     = S_PLACE;
            end
         end
         S_PLACE: begin
            if (hit) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = value_ff;
               wp_in       = idx_next;
               cnt_in      = cnt_ff + CNT_W'(1);
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_addr_ff <= '0;
         scan_left_ff <= RING_CNT;
         data_vld_ff  <= 1'b0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         scan_addr_ff <= scan_addr_in;
         scan_left_ff <= scan_left_in;
         data_vld_ff  <= data_vld_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
      end
      data_idx_ff <= data_idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      popped_ff   <= popped_in;
      status_ff   <= status_in;
   end

   `RSPR_ASSERT(a_cnt_bound, cnt_ff <= RING_CNT, "held count above ring size")
   `RSPR_ASSERT(a_wr_phase, mem_wr_en |-> (state_ff == S_CLEAR || scanning), "write outside scan")
   `RSPR_ASSERT(a_take_nonempty, state_ff == S_TAKE |-> cnt_ff != '0, "take scan on empty pool")
   `RSPR_ASSERT(a_place_room, state_ff == S_PLACE |-> cnt_ff < RING_CNT, "place scan on full pool")

endmodule

>>> rtl/core/ring_slot_pool_with_remove_unit.sv
// Pool of nonzero 32-bit handles in a ring of slots held in one synchronous RAM
// (CAPACITY rounded up to a power of two; zero marks an empty slot). One beat
// is worked at a time by a read-modify-write sequencer with one RAM read and
// one RAM write per cycle. After reset a clearing pass zeroes every slot of the
// RAM, one slot per cycle, with req_stall high. A push or pop probes slots from
// the write or read pointer until a free or held slot hits; a rejected or empty
// request goes to its result without a scan. A remove adds a search from slot 0
// and, when the handle is missing, a push-back scan. The next request can be
// taken in the cycle after the result is loaded, even while that result still
// waits on rsp_stall.
`include "ring_slot_pool_with_remove_unit_macros.svh"

module ring_slot_pool_with_remove_unit #(
   parameter int CAPACITY = rspr_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic [rspr_pkg::HANDLE_W-1:0]       req_handle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rspr_pkg::HANDLE_W-1:0]       rsp_popped_handle,
   output logic [1:0]                          rsp_status,
   output logic [rspr_pkg::COUNT_OUT_W-1:0]    rsp_item_count
);
   import rspr_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                  out_free;
   logic                  ctrl_fin;
   rspr_result_type       ctrl_result;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [HANDLE_W-1:0]   mem_rd_data;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [HANDLE_W-1:0]   mem_wr_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   rspr_result_type       rsp_data_ff,  rsp_data_in;

   rspr_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_handle    (req_handle),
      .out_free      (out_free),
      .fin           (ctrl_fin),
      .result        (ctrl_result),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data)
   );

   rspr_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock      (clock),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data)
   );

   // output beat register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (ctrl_fin) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ctrl_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_handle = rsp_data_ff.popped_handle;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_item_count    = rsp_data_ff.item_count;

   `RSPR_ASSERT(a_fin_free, ctrl_fin |-> out_free, "result loaded over a pending beat")
   `RSPR_ASSERT(a_fin_valid, ctrl_fin |=> rsp_valid_ff, "finished result not presented")
   `RSPR_ASSERT(a_accept_busy, (req_valid && !req_stall) |=> req_stall, "second accept while busy")

endmodule

>>> dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rspr_pkg::*;

   localparam int RING         = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 1500;
   localparam int QUIET_TAIL   = 200;
   localparam int DRAIN_CYCLES = 1200;
   localparam int CYCLE_LIMIT  = 6000000;
   localparam int PRINT_LIMIT  = 40;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} load_mode_type;

   typedef struct {
      rspr_op_type     op;
      logic [31:0]     handle;
      bit              typed;
      rspr_result_type want;
   } stim_row_type;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_operation = OP_PUSH;
   logic [HANDLE_W-1:0]    req_handle    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [HANDLE_W-1:0]    rsp_popped_handle;
   logic [1:0]             rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_item_count;

   ring_slot_pool_with_remove_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_handle        (req_handle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_popped_handle (rsp_popped_handle),
      .rsp_status        (rsp_status),
      .rsp_item_count    (rsp_item_count)
   );

   // pool shadow
   logic [31:0]     pool_slots [RING];
   int unsigned     pool_rd;
   int unsigned     pool_wr;
   int unsigned     pool_count;
   rspr_result_type pending_results [$];
   int              fail_count  = 0;
   int              cycle_count = 0;
   int              idle_pct    = 20;

   stim_row_type dir_rows [23] = '{
      '{OP_POP,     32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY,  9'd0}},
      '{OP_REMOVE,  32'h0000_1234, 1'b1, '{32'h0000_0000, ST_EMPTY,  9'd0}},
      '{OP_REMOVE,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_REJECT, 9'd0}},
      '{OP_PUSH,    32'h0000_0000, 1'b1, '{32'h0000_0000, ST_REJECT, 9'd0}},
      '{OP_INVALID, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_REJECT, 9'd0}},
      '{OP_PUSH,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,     9'd1}},
      '{OP_PUSH,    32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK,     9'd2}},
      '{OP_POP,     32'hDEAD_BEEF, 1'b1, '{32'hFFFF_FFFF, ST_OK,     9'd1}},
      '{OP_PUSH,    32'h0000_0005, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_PUSH,    32'h0000_0007, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_PUSH,    32'h0000_0005, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_REMOVE,  32'h0000_0007, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_REMOVE,  32'h0000_0063, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_REMOVE,  32'h0000_0005, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_PUSH,    32'h8000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_INVALID, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_REMOVE,  32'hFFFF_FFFF, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_REMOVE,  32'h8000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_POP,     32'h0000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_POP,     32'hFFFF_FFFF, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_POP,     32'h0000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_POP,     32'h0000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}},
      '{OP_POP,     32'h0000_0000, 1'b0, '{32'h0, ST_OK, 9'd0}}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t: %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
      end
   endtask

   function automatic bit pool_place(input logic [31:0] h);
      int unsigned ix;
      for (int n = 0; n < RING; n++) begin
         ix = pool_wr;
         pool_wr = (pool_wr + 1) % RING;
         if (pool_slots[ix] == '0) begin
            pool_slots[ix] = h;
            pool_count++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [31:0] pool_take();
      int unsigned ix;
      logic [31:0] h;
      if (pool_count == 0) return '0;
      for (int n = 0; n < RING; n++) begin
         ix = pool_rd;
         pool_rd = (pool_rd + 1) % RING;
         if (pool_slots[ix] != '0) begin
            h = pool_slots[ix];
            pool_slots[ix] = '0;
            pool_count--;
            return h;
         end
      end
      return '0;
   endfunction

   function automatic rspr_result_type pool_step(input rspr_op_type op,
                                                 input logic [31:0] h);
      rspr_result_type res;
      logic [31:0]     got;
      bit              found;
      res.popped_handle = '0;
      res.status        = ST_OK;
      case (op)
         OP_PUSH: begin
            if (h == '0 || pool_count >= RING) res.status = ST_REJECT;
            else if (!pool_place(h)) res.status = ST_REJECT;
         end
         OP_POP: begin
            res.popped_handle = pool_take();
            if (res.popped_handle == '0) res.status = ST_EMPTY;
         end
         OP_REMOVE: begin
            if (h == '0) begin
               res.status = ST_REJECT;
            end else begin
               got = pool_take();
               if (got == '0) begin
                  res.status = ST_EMPTY;
               end else if (got != h) begin
                  // lowest matching slot takes the popped handle
                  found = 1'b0;
                  for (int ix = 0; ix < RING; ix++) begin
                     if (!found && pool_slots[ix] == h) begin
                        pool_slots[ix] = got;
                        found = 1'b1;
                     end
                  end
                  if (!found) begin
                     void'(pool_place(got));
                     res.status = ST_NOT_FOUND;
                  end
               end
            end
         end
         default: res.status = ST_REJECT;
      endcase
      res.item_count = COUNT_OUT_W'(pool_count);
      return res;
   endfunction

   task automatic drive_beat(input rspr_op_type op, input logic [31:0] h, input bit typed,
                             input rspr_result_type want);
      rspr_result_type predicted;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_handle    <= h;
      do @(posedge clock); while (req_stall);
      predicted = pool_step(op, h);
      pending_results.push_back(typed ? want : predicted);
   endtask

   initial begin
      load_mode_type mode;
      rspr_op_type   op;
      logic [31:0]   h;
      int            r;
      foreach (pool_slots[ix]) pool_slots[ix] = '0;
      pool_rd    = 0;
      pool_wr    = 0;
      pool_count = 0;
      mode       = MODE_FILL;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[k]) begin
         drive_beat(dir_rows[k].op, dir_rows[k].handle, dir_rows[k].typed, dir_rows[k].want);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            // fill to the top, drain to empty, then wander
            if (i < 400) mode = MODE_FILL;
            else if (i < 800) mode = MODE_DRAIN;
            else mode = load_mode_type'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 5;
               2: idle_pct = 20;
               default: idle_pct = 40;
            endcase
         end
         if (i >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
         r = $urandom_range(0, 99);
         case (mode)
            MODE_FILL:  op = r < 80 ? OP_PUSH : r < 88 ? OP_POP : r < 98 ? OP_REMOVE : OP_INVALID;
            MODE_DRAIN: op = r < 10 ? OP_PUSH : r < 85 ? OP_POP : r < 98 ? OP_REMOVE : OP_INVALID;
            default:    op = r < 40 ? OP_PUSH : r < 65 ? OP_POP : r < 95 ? OP_REMOVE : OP_INVALID;
         endcase
         case ($urandom_range(0, 19))
            0:       h = '0;
            1:       h = 32'hFFFF_FFFF;
            2, 3, 4: h = $urandom;
            5, 6, 7, 8, 9: h = $urandom_range(1, 12);
            default: begin
               // mostly handles that are held right now
               h = '0;
               for (int t = 0; t < 16 && h == '0; t++) h = pool_slots[$urandom_range(0, RING - 1)];
               if (h == '0) h = $urandom_range(1, 12);
            end
         endcase
         drive_beat(op, h, 1'b0, '{32'h0, ST_OK, 9'd0});
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < idle_pct / 2) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rspr_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result with nothing pending", rsp_popped_handle, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_popped_handle !== want.popped_handle)
               note_mismatch("popped_handle", rsp_popped_handle, want.popped_handle);
            if (rsp_status !== want.status)
               note_mismatch("status", rsp_status, want.status);
            if (rsp_item_count !== want.item_count)
               note_mismatch("item_count", rsp_item_count, want.item_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d beats pending", pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
